[hdl/kev_pkg.sv]
// ----------------------------------------------------------------------------
// kev_pkg - shared types and constants of the key event detector
// Level and event codes, input selector codes, register indexes, the result
// entry type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kev_pkg;

  // Results held for one item; events of a scan past a full buffer are dropped.
  localparam int unsigned MAX_RES = 8;
  localparam int unsigned RES_IW  = 3;  // index into result buffer
  localparam int unsigned RES_CW  = 4;  // fill count, 0..MAX_RES

  // Configuration register indexes.
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_ACCEPT   = 3'd1;
  localparam logic [2:0] REG_DOUBLE   = 3'd2;
  localparam logic [2:0] REG_LONG     = 3'd3;
  localparam logic [2:0] REG_REPEAT   = 3'd4;
  localparam logic [2:0] REG_IDLE     = 3'd5;

  // Register reset values.
  localparam logic [15:0] RST_DEBOUNCE = 16'd20;
  localparam logic [15:0] RST_ACCEPT   = 16'd120;
  localparam logic [15:0] RST_DOUBLE   = 16'd500;
  localparam logic [19:0] RST_LONG     = 20'd5000;
  localparam logic [15:0] RST_REPEAT   = 16'd500;
  localparam logic [19:0] RST_IDLE     = 20'd30000;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_EDGE = 2'd1,
    FN_IDLE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    LVL_RELEASED = 2'd0,
    LVL_PRESSED  = 2'd1,
    LVL_LONG     = 2'd2
  } lvl_e;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONFIRM,
    ST_HOLD,
    ST_END,
    ST_QUERY,
    ST_DRAIN
  } ctl_state_e;

  typedef struct packed {
    logic       kind;
    logic [1:0] key_num;
    ev_e        code;
    logic       idle;
  } res_t;

  // Controller -> datapath
  typedef struct packed {
    logic pin_edge;   // record a pin edge from the input beat
    logic tick;       // advance time, start a scan
    logic confirm;    // debounce phase for the current key
    logic hold;       // long/repeat phase for the current key, step key
    logic idle_init;  // start an idle query
    logic idle_step;  // check one key for idle, step key
    logic pop;        // one result beat taken
  } kev_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_key;    // key counter at the last key
    logic res_empty;   // no result buffered
    logic drain_last;  // read pointer at the last buffered result
  } kev_sts_t;

endpackage

`default_nettype wire

[hdl/key_event_detector_unit.sv]
// ----------------------------------------------------------------------------
// key_event_detector_unit - debounced key events with double/long/repeat
// Per-key button event detector: pin edges, millisecond tick scans and idle
// queries in; press, release, double click, long, repeat and idle answers out.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: key, level
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: kind; tdata: key, code,
//                                               idle; tlast: last result
//  cfg       in   cfg_we_i (no back-pressure)   cfg_idx_i, cfg_data_i
//
//  Sequence: a pin edge is recorded as it is taken; a tick is accepted, then
//  gets a debounce and a long/repeat step per key and a wrap-up step, then its
//  result beats; an idle query checks each key, then gives its single beat.
//  Reset: all keys released, time zero, registers at their defaults.
//  Stalls: input is taken only between items; m_axis_tready low holds the
//  buffered result until taken. A tick with no events gives no beat.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_detector_unit
  import kev_pkg::*;
#(
  parameter int unsigned KEYS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] key_index, [2] pin_level
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // result item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [1:0] key_number, [4:2] event_code,
                                           // [5] all_idle
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);

  kev_cmd_t cmd;
  kev_sts_t sts;

  kev_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // s_axis_tdata[7:3] is padding
  kev_datapath #(
    .KEYS (KEYS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_index_i  (s_axis_tdata[1:0]),
    .pin_level_i  (s_axis_tdata[2]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

[hdl/kev_ctrl.sv]
// ----------------------------------------------------------------------------
// kev_ctrl - sequencing state machine
// Takes input beats, walks the keys in two phases per key for a tick or one
// phase per key for an idle query, then drains the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module kev_ctrl
  import kev_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [1:0] s_axis_tuser,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire kev_sts_t   sts_i,
  output kev_cmd_t        cmd_o
);

  ctl_state_e state_q, state_d;
  func_e      func;

  assign func = func_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (func)
            FN_TICK: begin
              cmd_o.tick = 1'b1;
              state_d    = ST_CONFIRM;
            end
            FN_EDGE: cmd_o.pin_edge = 1'b1;
            FN_IDLE: begin
              cmd_o.idle_init = 1'b1;
              state_d         = ST_QUERY;
            end
            default: ;  // unused selector, dropped
          endcase
        end
      end
      ST_CONFIRM: begin
        cmd_o.confirm = 1'b1;
        state_d       = ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.hold = 1'b1;
        state_d    = sts_i.last_key ? ST_END : ST_CONFIRM;
      end
      ST_END: begin
        state_d = sts_i.res_empty ? ST_IDLE : ST_DRAIN;
      end
      ST_QUERY: begin
        cmd_o.idle_step = 1'b1;
        if (sts_i.last_key) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cmd_o.pop = 1'b1;
          if (sts_i.drain_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/kev_datapath.sv]
// ----------------------------------------------------------------------------
// kev_datapath - time base, per-key state, configuration and result buffer
// One key is handled per command; results collect in an eight-entry buffer
// that is read out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module kev_datapath
  import kev_pkg::*;
#(
  parameter int unsigned KEYS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire kev_cmd_t    cmd_i,
  output kev_sts_t         sts_o,
  input  wire logic [1:0]  key_index_i,
  input  wire logic        pin_level_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned KW = (KEYS > 1) ? $clog2(KEYS) : 1;

  // configuration
  logic [15:0] deb_q, acc_q, dbl_q, rep_q;
  logic [19:0] long_q, idl_q;

  // time and key state
  logic [31:0]     now_q, now_d;
  lvl_e            level_q [KEYS];
  lvl_e            level_d [KEYS];
  logic [KEYS-1:0] pend_q, pend_d;
  logic [KEYS-1:0] conf_q, conf_d;
  logic [31:0]     act_q [KEYS];
  logic [31:0]     act_d [KEYS];
  logic [31:0]     lps_q [KEYS];
  logic [31:0]     lps_d [KEYS];
  logic [KW-1:0]   key_q, key_d;
  logic            idle_q, idle_d;

  // result buffer
  res_t              res_q [MAX_RES];
  logic [RES_CW-1:0] cnt_q, cnt_d;
  logic [RES_IW-1:0] rd_q, rd_d;

  logic [31:0]   act_age, lps_age;
  lvl_e          lvl_cur;
  logic          emit0, emit1, put_idle;
  ev_e           ev0, ev1;
  logic [RES_CW:0] cnt_sum;
  logic [1:0]    key_num;
  res_t          res_rd;

  assign lvl_cur = level_q[key_q];
  assign act_age = now_q - act_q[key_q];
  assign lps_age = now_q - lps_q[key_q];
  assign key_num = 2'(key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= RST_DEBOUNCE;
      acc_q  <= RST_ACCEPT;
      dbl_q  <= RST_DOUBLE;
      long_q <= RST_LONG;
      rep_q  <= RST_REPEAT;
      idl_q  <= RST_IDLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: deb_q  <= cfg_data_i[15:0];
        REG_ACCEPT:   acc_q  <= cfg_data_i[15:0];
        REG_DOUBLE:   dbl_q  <= cfg_data_i[15:0];
        REG_LONG:     long_q <= cfg_data_i;
        REG_REPEAT:   rep_q  <= cfg_data_i[15:0];
        REG_IDLE:     idl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    now_d    = now_q;
    level_d  = level_q;
    pend_d   = pend_q;
    conf_d   = conf_q;
    act_d    = act_q;
    lps_d    = lps_q;
    key_d    = key_q;
    idle_d   = idle_q;
    rd_d     = rd_q;
    emit0    = 1'b0;
    emit1    = 1'b0;
    ev0      = EV_PRESS;
    ev1      = EV_DOUBLE;
    put_idle = 1'b0;

    if (cmd_i.pin_edge) begin
      for (int i = 0; i < KEYS; i++) begin
        if (int'(key_index_i) == i) begin
          act_d[i]   = now_q;
          level_d[i] = pin_level_i ? LVL_RELEASED : LVL_PRESSED;
          pend_d[i]  = 1'b1;
        end
      end
    end

    if (cmd_i.tick) begin
      now_d = now_q + 32'd1;
      key_d = '0;
      rd_d  = '0;
    end

    if (cmd_i.confirm && pend_q[key_q]) begin
      if (act_age >= {16'd0, acc_q}) begin
        pend_d[key_q] = 1'b0;  // stale, dropped unconfirmed
      end else if (act_age >= {16'd0, deb_q}) begin
        pend_d[key_q] = 1'b0;
        case (lvl_cur)
          LVL_PRESSED: begin
            conf_d[key_q] = 1'b1;
            emit0         = 1'b1;
            ev0           = EV_PRESS;
            if (lps_age < {16'd0, dbl_q}) begin
              // double click; push stamp back so a third press is plain
              emit1         = 1'b1;
              ev1           = EV_DOUBLE;
              lps_d[key_q]  = now_q - {16'd0, dbl_q};
            end else begin
              lps_d[key_q] = now_q;
            end
          end
          LVL_RELEASED: begin
            if (conf_q[key_q]) begin
              conf_d[key_q] = 1'b0;
              emit0         = 1'b1;
              ev0           = EV_RELEASE;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.hold) begin
      key_d = key_q + KW'(1);
      case (lvl_cur)
        LVL_PRESSED: begin
          if (act_age >= {12'd0, long_q}) begin
            level_d[key_q] = LVL_LONG;
            act_d[key_q]   = now_q;
            emit0          = 1'b1;
            ev0            = EV_LONG;
          end
        end
        LVL_LONG: begin
          if (act_age >= {16'd0, rep_q}) begin
            act_d[key_q] = now_q;
            emit0        = 1'b1;
            ev0          = EV_REPEAT;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.idle_init) begin
      idle_d = 1'b1;
      key_d  = '0;
      rd_d   = '0;
    end

    if (cmd_i.idle_step) begin
      idle_d   = idle_q & (act_age >= {12'd0, idl_q});
      key_d    = key_q + KW'(1);
      put_idle = 1'b1;  // entry 0 rewritten each step, final one stays
    end

    if (cmd_i.pop) begin
      rd_d = rd_q + RES_IW'(1);
    end
  end

  // fill count saturates: overflowing events are dropped
  assign cnt_sum = {1'b0, cnt_q} + (RES_CW + 1)'(emit0) + (RES_CW + 1)'(emit1);

  always_comb begin
    if (cmd_i.tick || cmd_i.idle_init) begin
      cnt_d = '0;
    end else if (put_idle) begin
      cnt_d = RES_CW'(1);
    end else if (cnt_sum > (RES_CW + 1)'(MAX_RES)) begin
      cnt_d = RES_CW'(MAX_RES);
    end else begin
      cnt_d = cnt_sum[RES_CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      pend_q <= '0;
      conf_q <= '0;
      key_q  <= '0;
      idle_q <= 1'b0;
      cnt_q  <= '0;
      rd_q   <= '0;
      for (int i = 0; i < KEYS; i++) begin
        level_q[i] <= LVL_RELEASED;
        act_q[i]   <= '0;
        lps_q[i]   <= '0;
      end
    end else begin
      now_q   <= now_d;
      pend_q  <= pend_d;
      conf_q  <= conf_d;
      key_q   <= key_d;
      idle_q  <= idle_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      level_q <= level_d;
      act_q   <= act_d;
      lps_q   <= lps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (put_idle && j == 0) begin
        res_q[j] <= '{kind: 1'b1, key_num: 2'd0, code: EV_PRESS, idle: idle_d};
      end else if (emit0 && cnt_q == RES_CW'(j)) begin
        res_q[j] <= '{kind: 1'b0, key_num: key_num, code: ev0, idle: 1'b0};
      end else if (emit1 && (cnt_q + RES_CW'(1)) == RES_CW'(j)) begin
        res_q[j] <= '{kind: 1'b0, key_num: key_num, code: ev1, idle: 1'b0};
      end
    end
  end

  assign res_rd       = res_q[rd_q];
  assign m_axis_tdata = {2'b00, res_rd.idle, res_rd.code, res_rd.key_num};
  assign m_axis_tuser = res_rd.kind;
  assign m_axis_tlast = sts_o.drain_last;

  assign sts_o.last_key   = (key_q == KW'(KEYS - 1));
  assign sts_o.res_empty  = (cnt_q == '0);
  assign sts_o.drain_last = ({1'b0, rd_q} == (cnt_q - RES_CW'(1)));

  // a pop never runs past the buffered results
  a_pop_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> ({1'b0, rd_q} < cnt_q))
    else $error("result read beyond fill count");

  // fill count stays within the buffer
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CW'(MAX_RES))
    else $error("result fill count overflow");

  // an idle query leaves exactly one result
  a_idle_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.idle_step && sts_o.last_key) |=> (cnt_q == RES_CW'(1) && res_q[0].kind))
    else $error("idle query did not leave one answer");

  // a new tick empties the buffer
  a_tick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick |=> (cnt_q == '0 && rd_q == '0))
    else $error("scan started with stale results");

endmodule

`default_nettype wire
